// ===== src/fbre_pkg.sv =====
// Shared widths, codes and command/status types of the flat-bottom restraint energy block.
package fbre_pkg;

   localparam int COORD_W    = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int WEIGHT_W   = 16;
   localparam int FC_W       = 16;
   localparam int EDGE_W     = 20;
   localparam int DIST_W     = 21;
   localparam int ENERGY_W   = 48;
   localparam int SS_W       = 2 * DIST_W;
   localparam int EDIFF_W    = DIST_W + 1;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 27;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int WK_W       = WEIGHT_W + FC_W;
   localparam int FRAC_W     = 16;
   localparam int SUM_W      = PROD_W + 1;
   localparam int REM_W      = DIST_W + 3;
   localparam int ROOT_STEPS = DIST_W;
   localparam int CNT_W      = $clog2(ROOT_STEPS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [FC_W-1:0]   FC_RESET    = 16'd256;
   localparam logic [EDGE_W-1:0] LOWER_RESET = 20'd742;
   localparam logic [EDGE_W-1:0] UPPER_RESET = 20'd2048;

   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_CONSTANT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_EDGE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_EDGE     = 2'd2;

   typedef enum logic [2:0] {
      MUL_DX   = 3'd0,
      MUL_DY   = 3'd1,
      MUL_DZ   = 3'd2,
      MUL_WK   = 3'd3,
      MUL_EDGE = 3'd4,
      MUL_HI   = 3'd5,
      MUL_LO   = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        ss_load;
      logic        ss_add;
      logic        root_init;
      logic        root_step;
      logic        lo_load;
      logic        contrib_init;
      logic        contrib_add;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_stall;
   } status_type;

endpackage

// ===== src/fbre_ctrl.sv =====
// Sequencer for the restraint energy datapath: multiplies, square root steps, accumulate.
module fbre_ctrl import fbre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_MX    = 13'b0000000000010,
      ST_MY    = 13'b0000000000100,
      ST_MZ    = 13'b0000000001000,
      ST_MW    = 13'b0000000010000,
      ST_RINIT = 13'b0000000100000,
      ST_ROOT  = 13'b0000001000000,
      ST_EDGE  = 13'b0000010000000,
      ST_MH    = 13'b0000100000000,
      ST_ML    = 13'b0001000000000,
      ST_CL    = 13'b0010000000000,
      ST_FIN   = 13'b0100000000000,
      ST_SPARE = 13'b1000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_DX;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MX;
            end
         end
         ST_MX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DX;
            state_in    = ST_MY;
         end
         ST_MY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DY;
            cmd.ss_load = 1'b1;
            state_in    = ST_MZ;
         end
         ST_MZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DZ;
            cmd.ss_add  = 1'b1;
            state_in    = ST_MW;
         end
         ST_MW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_WK;
            cmd.ss_add  = 1'b1;
            state_in    = ST_RINIT;
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_EDGE;
            state_in    = ST_MH;
         end
         ST_MH: begin
            // high half of the squared offset goes in now, low half is kept
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HI;
            cmd.lo_load = 1'b1;
            state_in    = ST_ML;
         end
         ST_ML: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_LO;
            cmd.contrib_init = 1'b1;
            state_in         = ST_CL;
         end
         ST_CL: begin
            cmd.contrib_add = 1'b1;
            state_in        = ST_FIN;
         end
         ST_FIN: begin
            if (!status.out_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/fbre_dp.sv =====
// Datapath: CSRs, shared multiplier, bit-serial square root, saturating sum, result register.
module fbre_dp import fbre_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic                       csr_valid,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic signed [COORD_W-1:0]  req_first_x,
   input  logic signed [COORD_W-1:0]  req_first_y,
   input  logic signed [COORD_W-1:0]  req_first_z,
   input  logic signed [COORD_W-1:0]  req_second_x,
   input  logic signed [COORD_W-1:0]  req_second_y,
   input  logic signed [COORD_W-1:0]  req_second_z,
   input  logic signed [WEIGHT_W-1:0] req_pair_weight,
   input  logic                       req_last_pair,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DIST_W-1:0]          rsp_pair_distance,
   output logic signed [ENERGY_W-1:0] rsp_running_energy,
   output logic                       rsp_energy_saturated,
   output logic                       rsp_set_done
);

   logic [FC_W-1:0]            fc_ff;
   logic [EDGE_W-1:0]          lower_ff, upper_ff;
   logic signed [DIFF_W-1:0]   dx_ff, dy_ff, dz_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic                       last_ff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [SS_W-1:0]            ss_ff;
   logic signed [WK_W-1:0]     wk_ff;
   logic [SS_W-1:0]            rad_ff;
   logic [REM_W-1:0]           rem_ff, rem_sh, trial;
   logic [DIST_W-1:0]          root_ff;
   logic signed [EDIFF_W-1:0]  ediff;
   logic [FRAC_W-1:0]          lo_ff;
   logic signed [PROD_W-1:0]   contrib_ff;
   logic signed [ENERGY_W-1:0] energy_ff, energy_in;
   logic                       sat_flag_ff;
   logic signed [SUM_W-1:0]    sum_wide;
   logic                       sum_fits;
   logic                       rsp_valid_ff;
   logic [DIST_W-1:0]          rsp_dist_ff;
   logic signed [ENERGY_W-1:0] rsp_energy_ff;
   logic                       rsp_sat_ff, rsp_done_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff    <= FC_RESET;
         lower_ff <= LOWER_RESET;
         upper_ff <= UPPER_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FORCE_CONSTANT: fc_ff    <= csr_data[FC_W-1:0];
            CSR_LOWER_EDGE:     lower_ff <= csr_data[EDGE_W-1:0];
            CSR_UPPER_EDGE:     upper_ff <= csr_data[EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         dx_ff     <= DIFF_W'(req_first_x) - DIFF_W'(req_second_x);
         dy_ff     <= DIFF_W'(req_first_y) - DIFF_W'(req_second_y);
         dz_ff     <= DIFF_W'(req_first_z) - DIFF_W'(req_second_z);
         weight_ff <= req_pair_weight;
         last_ff   <= req_last_pair;
      end
   end

   // edge offset; d <= lower wins when the edges are crossed
   always_comb begin
      if ({1'b0, root_ff} <= {2'b00, lower_ff}) begin
         ediff = $signed({1'b0, root_ff}) - $signed({2'b00, lower_ff});
      end else if ({1'b0, root_ff} > {2'b00, upper_ff}) begin
         ediff = $signed({1'b0, root_ff}) - $signed({2'b00, upper_ff});
      end else begin
         ediff = '0;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_DX: begin
            mul_a = MUL_A_W'(dx_ff);
            mul_b = MUL_B_W'(dx_ff);
         end
         MUL_DY: begin
            mul_a = MUL_A_W'(dy_ff);
            mul_b = MUL_B_W'(dy_ff);
         end
         MUL_DZ: begin
            mul_a = MUL_A_W'(dz_ff);
            mul_b = MUL_B_W'(dz_ff);
         end
         MUL_WK: begin
            mul_a = MUL_A_W'(weight_ff);
            mul_b = MUL_B_W'($signed({1'b0, fc_ff}));
         end
         MUL_EDGE: begin
            mul_a = MUL_A_W'(ediff);
            mul_b = MUL_B_W'(ediff);
         end
         MUL_HI: begin
            mul_a = MUL_A_W'(wk_ff);
            mul_b = $signed({1'b0, prod_ff[SS_W-1:FRAC_W]});
         end
         MUL_LO: begin
            mul_a = MUL_A_W'(wk_ff);
            mul_b = MUL_B_W'($signed({1'b0, lo_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.ss_load) begin
         ss_ff <= prod_ff[SS_W-1:0];
      end else if (cmd.ss_add) begin
         ss_ff <= ss_ff + prod_ff[SS_W-1:0];
      end
      if (cmd.lo_load) begin
         lo_ff <= prod_ff[FRAC_W-1:0];
      end
      if (cmd.contrib_init) begin
         contrib_ff <= prod_ff - PROD_W'(wk_ff);
      end else if (cmd.contrib_add) begin
         // arithmetic shift floors the low partial product
         contrib_ff <= contrib_ff + (prod_ff >>> FRAC_W);
      end
   end

   // restoring square root, one result bit per cycle
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SS_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         wk_ff   <= prod_ff[WK_W-1:0];
         rad_ff  <= ss_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[SS_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[DIST_W-2:0], 1'b0};
         end
      end
   end

   // saturating accumulate
   assign sum_wide = SUM_W'(energy_ff) + SUM_W'(contrib_ff);
   assign sum_fits = (sum_wide[SUM_W-1:ENERGY_W-1] == '0)
                  || (sum_wide[SUM_W-1:ENERGY_W-1] == '1);

   always_comb begin
      if (sum_fits) begin
         energy_in = sum_wide[ENERGY_W-1:0];
      end else if (sum_wide[SUM_W-1]) begin
         energy_in = {1'b1, {(ENERGY_W-1){1'b0}}};
      end else begin
         energy_in = {1'b0, {(ENERGY_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff   <= '0;
         sat_flag_ff <= 1'b0;
      end else if (cmd.out_load) begin
         if (last_ff) begin
            energy_ff   <= '0;
            sat_flag_ff <= 1'b0;
         end else begin
            energy_ff   <= energy_in;
            sat_flag_ff <= sat_flag_ff | ~sum_fits;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_dist_ff   <= root_ff;
         rsp_energy_ff <= energy_in;
         rsp_sat_ff    <= sat_flag_ff | ~sum_fits;
         rsp_done_ff   <= last_ff;
      end
   end

   assign status.out_stall     = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pair_distance    = rsp_dist_ff;
   assign rsp_running_energy   = rsp_energy_ff;
   assign rsp_energy_saturated = rsp_sat_ff;
   assign rsp_set_done         = rsp_done_ff;

endmodule

// ===== src/flat_bottom_pair_restraint_energy.sv =====
// Flat-bottom harmonic distance restraint energy: top level.
// Usage:
//   req_* : one restraint pair per transaction (two Q12.8 positions, Q8.8 weight,
//           last_pair flag); taken while req_ready is high.
//   rsp_* : one result per pair: distance (Q13.8), running energy sum (Q32.16,
//           saturating), saturation flag of the set, set_done = last_pair.
//   csr_* : writes force_constant (0), lower_edge (1), upper_edge (2); ready
//           outside reset, only to be written while no pair is in flight.
// Sequence: each pair runs through the 21-step bit-serial square root plus
//   seven passes through the single shared 33x27 multiplier; a new pair is
//   accepted only once the previous one has been loaded into the result
//   register.
// The result register decouples the sides: a finished result waits there
//   while the next pair is accepted; if the previous result is still not
//   taken when the next one is ready, the sequencer holds until rsp_ready.
// Reset: CSRs return to 1.0 / 2.9 / 8.0, the sum and flag clear, no result is
//   pending. The sum and flag also clear after the pair marked last.
module flat_bottom_pair_restraint_energy import fbre_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_first_x,
   input  logic signed [COORD_W-1:0]  req_first_y,
   input  logic signed [COORD_W-1:0]  req_first_z,
   input  logic signed [COORD_W-1:0]  req_second_x,
   input  logic signed [COORD_W-1:0]  req_second_y,
   input  logic signed [COORD_W-1:0]  req_second_z,
   input  logic signed [WEIGHT_W-1:0] req_pair_weight,
   input  logic                       req_last_pair,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DIST_W-1:0]          rsp_pair_distance,
   output logic signed [ENERGY_W-1:0] rsp_running_energy,
   output logic                       rsp_energy_saturated,
   output logic                       rsp_set_done,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !reset;

   fbre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fbre_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_first_x          (req_first_x),
      .req_first_y          (req_first_y),
      .req_first_z          (req_first_z),
      .req_second_x         (req_second_x),
      .req_second_y         (req_second_y),
      .req_second_z         (req_second_z),
      .req_pair_weight      (req_pair_weight),
      .req_last_pair        (req_last_pair),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pair_distance    (rsp_pair_distance),
      .rsp_running_energy   (rsp_running_energy),
      .rsp_energy_saturated (rsp_energy_saturated),
      .rsp_set_done         (rsp_set_done)
   );

`ifndef ASSERT_OFF
   // one pair in the datapath at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a pair is in flight");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && !rsp_ready))
      else $error("result register overwritten before transaction");

   // loading a result presents it next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");
`endif

endmodule
